// ===== design/bdq_pkg.sv =====
// shared types, widths and request codes for the byte deque buffer
`timescale 1ns / 1ps

package bdq_pkg;

  // field widths of the request and result ports
  localparam int TYPE_W = 4;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 13;

  // default sizes
  localparam int DEPTH_DEF     = 4096;
  localparam int MAX_BURST_DEF = 64;

  // request codes
  typedef enum logic [TYPE_W-1:0] {
    REQ_PUT_BACK    = 4'd0,
    REQ_UNGET_FRONT = 4'd1,
    REQ_GET_FRONT   = 4'd2,
    REQ_UNPUT_BACK  = 4'd3,
    REQ_PEEK_FRONT  = 4'd4,
    REQ_PEEK_BACK   = 4'd5,
    REQ_GET_BURST   = 4'd6,
    REQ_PEEK_BURST  = 4'd7,
    REQ_DISCARD     = 4'd8,
    REQ_FILL        = 4'd9
  } req_t;

endpackage

// ===== design/bdq_ram.sv =====
// generic single write port, single read port ram with registered read data
`timescale 1ns / 1ps

module bdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/byte_deque_buffer.sv =====
// top level of the double-ended byte queue: ring store, sequencer and result register
//
//  channel   handshake            payload
//  request   req_valid/req_stall  req_type, data_byte, count
//  result    res_valid/res_stall  out_byte, out_valid, out_last, moved_count,
//                                 fill_level, overflow
//
// a request is taken only while the sequencer is idle; one ring adder
// (add with wrap at DEPTH) serves every pointer update, one step a cycle.
// put, unget, discard, zero-byte fill: decode, exec, emit; unknown codes, writes to a
// full queue, reads and bursts on an empty queue: decode, emit; single reads:
// decode, exec, rd (ram read latency), emit; bursts: decode, exec, then brd, bdat,
// emit for each byte; fill: decode, exec, then one ram write per byte, then emit.
// a stalled result holds the sequencer in its emit step until taken.
// synchronous reset empties the queue; store contents are not cleared.
`timescale 1ns / 1ps

module byte_deque_buffer #(
  parameter int DEPTH     = bdq_pkg::DEPTH_DEF,
  parameter int MAX_BURST = bdq_pkg::MAX_BURST_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // request channel
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [bdq_pkg::TYPE_W-1:0] req_type,
  input  logic [bdq_pkg::BYTE_W-1:0] data_byte,
  input  logic [bdq_pkg::CNT_W-1:0]  count,
  // result channel
  output logic                       res_valid,
  input  logic                       res_stall,
  output logic [bdq_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_valid,
  output logic                       out_last,
  output logic [bdq_pkg::CNT_W-1:0]  moved_count,
  output logic [bdq_pkg::CNT_W-1:0]  fill_level,
  output logic                       overflow
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int NW = (CW > bdq_pkg::CNT_W) ? CW : bdq_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_RD,
    S_BRD,
    S_BDAT,
    S_FILLW,
    S_EMIT
  } state_t;

  state_t                      state;
  bdq_pkg::req_t               rtype;
  logic [bdq_pkg::BYTE_W-1:0]  rdata;
  logic [bdq_pkg::CNT_W-1:0]   rcnt;
  logic [AW-1:0]               head;
  logic [CW-1:0]               fill;
  logic [CW-1:0]               n_bytes;
  logic [CW-1:0]               idx;
  logic [AW-1:0]               ptr;
  logic [bdq_pkg::BYTE_W-1:0]  byte_hold;
  logic                        bvalid;
  logic [CW-1:0]               moved;
  logic                        ovf;

  // request is taken only when idle
  assign req_stall = (state != S_IDLE);

  // length limits worked out in the decode step
  logic [NW-1:0] cnt_w, fill_w, room_w, cap_w, n_burst, n_disc, n_fill;
  logic          fill_short, is_full, is_empty;

  always_comb begin
    cnt_w      = NW'(rcnt);
    fill_w     = NW'(fill);
    room_w     = NW'(DEPTH) - fill_w;
    cap_w      = (cnt_w < NW'(MAX_BURST)) ? cnt_w : NW'(MAX_BURST);
    n_burst    = (cap_w < fill_w) ? cap_w : fill_w;
    n_disc     = (cnt_w < fill_w) ? cnt_w : fill_w;
    fill_short = (cnt_w > room_w);
    n_fill     = fill_short ? room_w : cnt_w;
    is_full    = (fill == CW'(DEPTH));
    is_empty   = (fill == '0);
  end

  // classify request, size its work, pick the step after decode
  logic          bvalid_next;
  logic [CW-1:0] moved_next;
  logic          ovf_next;
  logic [CW-1:0] n_bytes_next;
  state_t        dec_state;

  always_comb begin
    bvalid_next  = 1'b0;
    moved_next   = '0;
    ovf_next     = 1'b0;
    n_bytes_next = '0;
    dec_state    = S_EMIT;
    case (rtype)
      bdq_pkg::REQ_PUT_BACK, bdq_pkg::REQ_UNGET_FRONT: begin
        if (is_full) begin
          ovf_next = 1'b1;
        end else begin
          moved_next = CW'(1);
          dec_state  = S_EXEC;
        end
      end
      bdq_pkg::REQ_GET_FRONT, bdq_pkg::REQ_UNPUT_BACK,
      bdq_pkg::REQ_PEEK_FRONT, bdq_pkg::REQ_PEEK_BACK: begin
        if (!is_empty) begin
          bvalid_next = 1'b1;
          moved_next  = (rtype inside {bdq_pkg::REQ_GET_FRONT,
                                       bdq_pkg::REQ_UNPUT_BACK}) ? CW'(1) : '0;
          dec_state   = S_EXEC;
        end
      end
      bdq_pkg::REQ_GET_BURST, bdq_pkg::REQ_PEEK_BURST: begin
        if (n_burst != '0) begin
          bvalid_next  = 1'b1;
          moved_next   = CW'(n_burst);
          n_bytes_next = CW'(n_burst);
          dec_state    = S_EXEC;
        end
      end
      bdq_pkg::REQ_DISCARD: begin
        moved_next   = CW'(n_disc);
        n_bytes_next = CW'(n_disc);
        dec_state    = S_EXEC;
      end
      bdq_pkg::REQ_FILL: begin
        moved_next   = CW'(n_fill);
        n_bytes_next = CW'(n_fill);
        ovf_next     = fill_short;
        dec_state    = S_EXEC;
      end
      default: dec_state = S_EMIT;
    endcase
  end

  // shared ring adder: base plus offset, wrapped at DEPTH
  logic [AW-1:0] ring_base;
  logic [CW-1:0] ring_off;
  logic [SW-1:0] ring_sum, ring_res;
  logic [AW-1:0] ring_pos;

  always_comb begin
    ring_base = head;
    ring_off  = '0;
    case (state)
      S_EXEC: begin
        case (rtype)
          bdq_pkg::REQ_PUT_BACK:    ring_off = fill;
          bdq_pkg::REQ_UNGET_FRONT: ring_off = CW'(DEPTH - 1);
          bdq_pkg::REQ_GET_FRONT:   ring_off = CW'(1);
          bdq_pkg::REQ_UNPUT_BACK,
          bdq_pkg::REQ_PEEK_BACK:   ring_off = fill - CW'(1);
          bdq_pkg::REQ_GET_BURST,
          bdq_pkg::REQ_PEEK_BURST,
          bdq_pkg::REQ_DISCARD:     ring_off = n_bytes;
          bdq_pkg::REQ_FILL:        ring_off = fill;
          default:                  ring_off = '0;
        endcase
      end
      S_BDAT, S_FILLW: begin
        ring_base = ptr;
        ring_off  = CW'(1);
      end
      default: ring_off = '0;
    endcase
    ring_sum = SW'(ring_base) + SW'(ring_off);
    ring_res = (ring_sum >= SW'(DEPTH)) ? ring_sum - SW'(DEPTH) : ring_sum;
    ring_pos = ring_res[AW-1:0];
  end

  // store port control
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [AW-1:0]              ram_raddr;
  logic [bdq_pkg::BYTE_W-1:0] ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ring_pos;
    ram_raddr = head;
    case (state)
      S_EXEC: begin
        if (rtype inside {bdq_pkg::REQ_PUT_BACK, bdq_pkg::REQ_UNGET_FRONT}) begin
          ram_we = 1'b1;
        end
        if (rtype inside {bdq_pkg::REQ_UNPUT_BACK, bdq_pkg::REQ_PEEK_BACK}) begin
          ram_raddr = ring_pos;
        end
      end
      S_FILLW: begin
        ram_we    = 1'b1;
        ram_waddr = ptr;
      end
      S_BRD: ram_raddr = ptr;
      default: ram_we = 1'b0;
    endcase
  end

  bdq_ram #(
    .WIDTH (bdq_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (rdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // result slot can take a new item
  logic slot_free;
  logic in_burst;
  logic burst_last;

  assign slot_free  = !res_valid || !res_stall;
  assign in_burst   = bvalid && (rtype inside {bdq_pkg::REQ_GET_BURST,
                                               bdq_pkg::REQ_PEEK_BURST});
  assign burst_last = ((idx + CW'(1)) == n_bytes);

  // sequencer, queue state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      fill      <= '0;
      res_valid <= 1'b0;
    end else begin
      // taken result leaves the slot; the emit step reloads it itself
      if (res_valid && !res_stall && state != S_EMIT) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            rtype <= bdq_pkg::req_t'(req_type);
            rdata <= data_byte;
            rcnt  <= count;
            state <= S_DECODE;
          end
        end

        // latch the sizing of the request
        S_DECODE: begin
          bvalid  <= bvalid_next;
          moved   <= moved_next;
          ovf     <= ovf_next;
          n_bytes <= n_bytes_next;
          state   <= dec_state;
        end

        // pointer and fill updates, first store access
        S_EXEC: begin
          idx <= '0;
          case (rtype)
            bdq_pkg::REQ_PUT_BACK: begin
              fill  <= fill + CW'(1);
              state <= S_EMIT;
            end
            bdq_pkg::REQ_UNGET_FRONT: begin
              head  <= ring_pos;
              fill  <= fill + CW'(1);
              state <= S_EMIT;
            end
            bdq_pkg::REQ_GET_FRONT: begin
              head  <= ring_pos;
              fill  <= fill - CW'(1);
              state <= S_RD;
            end
            bdq_pkg::REQ_UNPUT_BACK: begin
              fill  <= fill - CW'(1);
              state <= S_RD;
            end
            bdq_pkg::REQ_PEEK_FRONT, bdq_pkg::REQ_PEEK_BACK: begin
              state <= S_RD;
            end
            bdq_pkg::REQ_GET_BURST, bdq_pkg::REQ_PEEK_BURST: begin
              ptr <= head;
              if (rtype == bdq_pkg::REQ_GET_BURST) begin
                head <= ring_pos;
                fill <= fill - n_bytes;
              end
              state <= S_BRD;
            end
            bdq_pkg::REQ_DISCARD: begin
              head  <= ring_pos;
              fill  <= fill - n_bytes;
              state <= S_EMIT;
            end
            bdq_pkg::REQ_FILL: begin
              ptr   <= ring_pos;
              fill  <= fill + n_bytes;
              state <= (n_bytes == '0) ? S_EMIT : S_FILLW;
            end
            default: state <= S_EMIT;
          endcase
        end

        // single read data back from the store
        S_RD: begin
          byte_hold <= ram_rdata;
          state     <= S_EMIT;
        end

        // burst read issued at ptr
        S_BRD: state <= S_BDAT;

        // burst byte back, advance the read pointer
        S_BDAT: begin
          byte_hold <= ram_rdata;
          ptr       <= ring_pos;
          state     <= S_EMIT;
        end

        // one fill byte written per cycle
        S_FILLW: begin
          ptr <= ring_pos;
          idx <= idx + CW'(1);
          if (burst_last) begin
            state <= S_EMIT;
          end
        end

        // hand one result item to the output register
        S_EMIT: begin
          if (slot_free) begin
            res_valid   <= 1'b1;
            out_byte    <= bvalid ? byte_hold : '0;
            out_valid   <= bvalid;
            out_last    <= !in_burst || burst_last;
            moved_count <= bdq_pkg::CNT_W'(moved);
            fill_level  <= bdq_pkg::CNT_W'(fill);
            overflow    <= ovf;
            if (in_burst && !burst_last) begin
              idx   <= idx + CW'(1);
              state <= S_BRD;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // fill never passes the store size
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("fill count above depth");

  // head pointer stays inside the ring
  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head < AW'(DEPTH - 1) || head == AW'(DEPTH - 1))
    else $error("head pointer outside ring");

  // a result that is not the last of its request carries a byte
  a_nonlast_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_last |-> out_valid)
    else $error("non-final result without a byte");

  // queue state does not move while idle
  a_idle_stable: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |=> $stable(fill) && $stable(head))
    else $error("queue state changed while idle");

  // a new result is loaded only into a free slot
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(out_byte) && $stable(fill_level))
    else $error("held result overwritten");

endmodule
